// ===== hw/rtl/bals_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants of the ballistic apex launch solver.
// Depends on nothing; the top level imports it.
package bals_pkg;

   localparam int BALS_FRAC_BITS = 16;
   localparam int BALS_COORD_W   = 32;
   localparam int BALS_MAG_W     = 31;

   localparam logic signed [BALS_COORD_W-1:0] BALS_GRAVITY_RESET = -32'sd642253;

   typedef struct packed {
      logic signed [BALS_COORD_W-1:0] start_x;
      logic signed [BALS_COORD_W-1:0] start_y;
      logic signed [BALS_COORD_W-1:0] start_z;
      logic signed [BALS_COORD_W-1:0] target_x;
      logic signed [BALS_COORD_W-1:0] target_y;
      logic signed [BALS_COORD_W-1:0] target_z;
      logic signed [BALS_COORD_W-1:0] arc_height;
   } bals_req_type;

   typedef struct packed {
      logic                           solved;
      logic signed [BALS_COORD_W-1:0] vel_x;
      logic        [BALS_MAG_W-1:0]   vel_y;
      logic signed [BALS_COORD_W-1:0] vel_z;
      logic        [BALS_MAG_W-1:0]   flight_time;
   } bals_rsp_type;

endpackage

// ===== hw/rtl/bals_div_cell.sv =====
`timescale 1ns / 1ps
// One registered restoring division step: shifts in a numerator bit,
// subtracts the divisor when it fits and appends the quotient bit. No dependencies.
module bals_div_cell #(
   parameter int NUM_W  = 32,
   parameter int DEN_W  = 32,
   parameter int QUO_W  = 32,
   parameter int SIDE_W = 1
) (
   input  logic              clock,
   input  logic              en,
   input  logic [NUM_W-1:0]  num_i,
   input  logic [DEN_W-1:0]  den_i,
   input  logic [DEN_W-1:0]  rem_i,
   input  logic [QUO_W-1:0]  quo_i,
   input  logic [SIDE_W-1:0] side_i,
   output logic [NUM_W-1:0]  num_o,
   output logic [DEN_W-1:0]  den_o,
   output logic [DEN_W-1:0]  rem_o,
   output logic [QUO_W-1:0]  quo_o,
   output logic [SIDE_W-1:0] side_o
);

   logic [DEN_W:0]   part;
   logic [DEN_W:0]   diff;
   logic             ge;
   logic [NUM_W-1:0] num_in;
   logic [DEN_W-1:0] rem_in;
   logic [QUO_W-1:0] quo_in;

   logic [NUM_W-1:0]  num_ff;
   logic [DEN_W-1:0]  den_ff;
   logic [DEN_W-1:0]  rem_ff;
   logic [QUO_W-1:0]  quo_ff;
   logic [SIDE_W-1:0] side_ff;

   always_comb begin
      part   = {rem_i, num_i[NUM_W-1]};
      diff   = part - {1'b0, den_i};
      ge     = (part >= {1'b0, den_i});
      rem_in = ge ? diff[DEN_W-1:0] : part[DEN_W-1:0];
      num_in = {num_i[NUM_W-2:0], 1'b0};
      quo_in = {quo_i[QUO_W-2:0], ge};
   end

   always_ff @(posedge clock) begin
      if (en) begin
         num_ff  <= num_in;
         den_ff  <= den_i;
         rem_ff  <= rem_in;
         quo_ff  <= quo_in;
         side_ff <= side_i;
      end
   end

   assign num_o  = num_ff;
   assign den_o  = den_ff;
   assign rem_o  = rem_ff;
   assign quo_o  = quo_ff;
   assign side_o = side_ff;

endmodule

// ===== hw/rtl/bals_sqrt_cell.sv =====
`timescale 1ns / 1ps
// One registered digit-by-digit square root step, two radicand bits in
// and one root bit out. No dependencies.
module bals_sqrt_cell #(
   parameter int RAD_W  = 64,
   parameter int SIDE_W = 1
) (
   input  logic              clock,
   input  logic              en,
   input  logic [RAD_W-1:0]  rad_i,
   input  logic [RAD_W/2+1:0] rem_i,
   input  logic [RAD_W/2-1:0] root_i,
   input  logic [SIDE_W-1:0] side_i,
   output logic [RAD_W-1:0]  rad_o,
   output logic [RAD_W/2+1:0] rem_o,
   output logic [RAD_W/2-1:0] root_o,
   output logic [SIDE_W-1:0] side_o
);

   localparam int ROOT_W = RAD_W / 2;

   logic [ROOT_W+1:0] part;
   logic [ROOT_W+1:0] trial;
   logic              ge;
   logic [ROOT_W+1:0] rem_in;
   logic [ROOT_W-1:0] root_in;
   logic [RAD_W-1:0]  rad_in;

   logic [RAD_W-1:0]  rad_ff;
   logic [ROOT_W+1:0] rem_ff;
   logic [ROOT_W-1:0] root_ff;
   logic [SIDE_W-1:0] side_ff;

   always_comb begin
      part    = {rem_i[ROOT_W-1:0], rad_i[RAD_W-1:RAD_W-2]};
      trial   = {root_i, 2'b01};
      ge      = (part >= trial);
      rem_in  = ge ? (part - trial) : part;
      root_in = {root_i[ROOT_W-2:0], ge};
      rad_in  = {rad_i[RAD_W-3:0], 2'b00};
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rad_ff  <= rad_in;
         rem_ff  <= rem_in;
         root_ff <= root_in;
         side_ff <= side_i;
      end
   end

   assign rad_o  = rad_ff;
   assign rem_o  = rem_ff;
   assign root_o = root_ff;
   assign side_o = side_ff;

endmodule

// ===== hw/rtl/ballistic_apex_launch_solver.sv =====
`timescale 1ns / 1ps
// Ballistic apex launch solver, top level. Uses bals_pkg, bals_div_cell, bals_sqrt_cell.
// A request passes the input register, stages s1 and s2, the time division chain, the square root
// chain, stage t, the velocity division chain and the output register.
// Throughput is one request per cycle; the whole pipeline holds while a result is stalled.
// Synchronous reset empties the pipeline and sets gravity to about -9.8.
module ballistic_apex_launch_solver import bals_pkg::*; #(
   parameter int FRAC_BITS = BALS_FRAC_BITS
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  bals_req_type            req_data,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output bals_rsp_type            rsp_data,
   input  logic                    csr_valid,
   output logic                    csr_ready,
   input  logic [BALS_COORD_W-1:0] csr_data
);

   localparam int NA       = 35 + 2 * FRAC_BITS;
   localparam int NUMA_W   = 35;
   localparam int DENA_W   = 32;
   localparam int QX_W     = (NA > 64) ? NA : 64;
   localparam int RAD_W    = 64;
   localparam int ROOT_W   = RAD_W / 2;
   localparam int NB       = ROOT_W;
   localparam int NC       = 32 + FRAC_BITS;
   localparam int NUMC_W   = 32;
   localparam int DENC_W   = 31;
   localparam int MIN_RAW  = ((1 << FRAC_BITS) + 500) / 1000;
   localparam int MIN_TIME = (MIN_RAW < 1) ? 1 : MIN_RAW;
   localparam logic [BALS_MAG_W-1:0] MAX31 = {BALS_MAG_W{1'b1}};

   logic en;
   logic signed [31:0] gravity_ff;

   assign en        = !(rsp_valid && rsp_stall);
   assign req_stall = !en;
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         gravity_ff <= BALS_GRAVITY_RESET;
      end else if (csr_valid) begin
         gravity_ff <= csr_data;
      end
   end

   logic         in_vld_ff;
   bals_req_type in_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff <= 1'b0;
      end else if (en) begin
         in_vld_ff <= req_valid;
      end
      if (en) begin
         in_ff <= req_data;
      end
   end

   logic signed [33:0] sy34, ty34, arc34, hi34, apex34, rise_s, fall_s;
   logic [33:0]        rise_in, fall_in;
   logic [31:0]        g_in;
   logic signed [32:0] dx_in, dz_in;

   always_comb begin
      sy34    = {{2{in_ff.start_y[31]}}, in_ff.start_y};
      ty34    = {{2{in_ff.target_y[31]}}, in_ff.target_y};
      arc34   = {{2{in_ff.arc_height[31]}}, in_ff.arc_height};
      hi34    = (sy34 > ty34) ? sy34 : ty34;
      apex34  = hi34 + arc34;
      rise_s  = apex34 - sy34;
      fall_s  = apex34 - ty34;
      rise_in = rise_s[33] ? 34'd0 : rise_s;
      fall_in = fall_s[33] ? 34'd0 : fall_s;
      g_in    = 32'(-gravity_ff);
      dx_in   = {in_ff.target_x[31], in_ff.target_x} - {in_ff.start_x[31], in_ff.start_x};
      dz_in   = {in_ff.target_z[31], in_ff.target_z} - {in_ff.start_z[31], in_ff.start_z};
   end

   logic               s1_vld_ff, s1_ok_ff;
   logic [31:0]        s1_g_ff;
   logic [33:0]        s1_rise_ff, s1_fall_ff;
   logic signed [32:0] s1_dx_ff, s1_dz_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff <= 1'b0;
      end else if (en) begin
         s1_vld_ff <= in_vld_ff;
      end
      if (en) begin
         s1_ok_ff   <= gravity_ff[31];
         s1_g_ff    <= g_in;
         s1_rise_ff <= rise_in;
         s1_fall_ff <= fall_in;
         s1_dx_ff   <= dx_in;
         s1_dz_ff   <= dz_in;
      end
   end

   logic               s2_vld_ff, s2_ok_ff;
   logic [31:0]        s2_g_ff;
   logic [33:0]        s2_rise_ff, s2_fall_ff;
   logic signed [32:0] s2_dx_ff, s2_dz_ff;
   logic [48:0]        s2_pp_lo_ff, s2_pp_hi_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_vld_ff <= 1'b0;
      end else if (en) begin
         s2_vld_ff <= s1_vld_ff;
      end
      if (en) begin
         s2_ok_ff    <= s1_ok_ff;
         s2_g_ff     <= s1_g_ff;
         s2_rise_ff  <= s1_rise_ff;
         s2_fall_ff  <= s1_fall_ff;
         s2_dx_ff    <= s1_dx_ff;
         s2_dz_ff    <= s1_dz_ff;
         s2_pp_lo_ff <= s1_g_ff * s1_rise_ff[16:0];
         s2_pp_hi_ff <= s1_g_ff * s1_rise_ff[33:17];
      end
   end

   logic [65:0] prod;
   logic        vysat;
   logic [63:0] rad_vy;

   always_comb begin
      prod   = {s2_pp_hi_ff, 17'd0} + 66'(s2_pp_lo_ff);
      vysat  = |prod[65:61];
      rad_vy = {prod[62:0], 1'b0};
   end

   // Time division chains for the rise and the fall heights.
   localparam int SAR_W = 66;
   localparam int SAF_W = 66;

   logic [NUMA_W-1:0] ar_num  [0:NA];
   logic [DENA_W-1:0] ar_den  [0:NA];
   logic [DENA_W-1:0] ar_rem  [0:NA];
   logic [NA-1:0]     ar_quo  [0:NA];
   logic [SAR_W-1:0]  ar_side [0:NA];
   logic [NUMA_W-1:0] af_num  [0:NA];
   logic [DENA_W-1:0] af_den  [0:NA];
   logic [DENA_W-1:0] af_rem  [0:NA];
   logic [NA-1:0]     af_quo  [0:NA];
   logic [SAF_W-1:0]  af_side [0:NA];
   logic [NA-1:0]     va_ff;

   assign ar_num[0]  = {s2_rise_ff, 1'b0};
   assign ar_den[0]  = s2_g_ff;
   assign ar_rem[0]  = '0;
   assign ar_quo[0]  = '0;
   assign ar_side[0] = {rad_vy, vysat, s2_ok_ff};
   assign af_num[0]  = {s2_fall_ff, 1'b0};
   assign af_den[0]  = s2_g_ff;
   assign af_rem[0]  = '0;
   assign af_quo[0]  = '0;
   assign af_side[0] = {s2_dx_ff, s2_dz_ff};

   for (genvar i = 0; i < NA; i++) begin : g_div_a
      bals_div_cell #(
         .NUM_W(NUMA_W), .DEN_W(DENA_W), .QUO_W(NA), .SIDE_W(SAR_W)
      ) u_rise (
         .clock(clock), .en(en),
         .num_i(ar_num[i]), .den_i(ar_den[i]), .rem_i(ar_rem[i]),
         .quo_i(ar_quo[i]), .side_i(ar_side[i]),
         .num_o(ar_num[i+1]), .den_o(ar_den[i+1]), .rem_o(ar_rem[i+1]),
         .quo_o(ar_quo[i+1]), .side_o(ar_side[i+1])
      );
      bals_div_cell #(
         .NUM_W(NUMA_W), .DEN_W(DENA_W), .QUO_W(NA), .SIDE_W(SAF_W)
      ) u_fall (
         .clock(clock), .en(en),
         .num_i(af_num[i]), .den_i(af_den[i]), .rem_i(af_rem[i]),
         .quo_i(af_quo[i]), .side_i(af_side[i]),
         .num_o(af_num[i+1]), .den_o(af_den[i+1]), .rem_o(af_rem[i+1]),
         .quo_o(af_quo[i+1]), .side_o(af_side[i+1])
      );
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         va_ff <= '0;
      end else if (en) begin
         va_ff <= {va_ff[NA-2:0], s2_vld_ff};
      end
   end

   localparam logic [QX_W-1:0]  RAD_CAP_X = QX_W'(1) << 62;
   localparam logic [RAD_W-1:0] RAD_CAP   = RAD_W'(1) << 62;

   logic [QX_W-1:0]    qr_x, qf_x;
   logic [RAD_W-1:0]   rad_r, rad_f;
   logic [63:0]        a_rad_vy;
   logic               a_vysat, a_ok;
   logic signed [32:0] a_dx, a_dz;

   always_comb begin
      qr_x     = QX_W'(ar_quo[NA]);
      qf_x     = QX_W'(af_quo[NA]);
      rad_r    = (qr_x >= RAD_CAP_X) ? RAD_CAP : qr_x[RAD_W-1:0];
      rad_f    = (qf_x >= RAD_CAP_X) ? RAD_CAP : qf_x[RAD_W-1:0];
      a_rad_vy = ar_side[NA][65:2];
      a_vysat  = ar_side[NA][1];
      a_ok     = ar_side[NA][0];
      a_dx     = af_side[NA][65:33];
      a_dz     = af_side[NA][32:0];
   end

   // Square root chains: rise time, fall time and upward speed.
   logic [RAD_W-1:0]  br_rad [0:NB];
   logic [ROOT_W+1:0] br_rem [0:NB];
   logic [ROOT_W-1:0] br_root [0:NB];
   logic [33:0]       br_side [0:NB];
   logic [RAD_W-1:0]  bf_rad [0:NB];
   logic [ROOT_W+1:0] bf_rem [0:NB];
   logic [ROOT_W-1:0] bf_root [0:NB];
   logic [32:0]       bf_side [0:NB];
   logic [RAD_W-1:0]  bv_rad [0:NB];
   logic [ROOT_W+1:0] bv_rem [0:NB];
   logic [ROOT_W-1:0] bv_root [0:NB];
   logic [0:0]        bv_side [0:NB];
   logic [NB-1:0]     vb_ff;

   assign br_rad[0]  = rad_r;
   assign br_rem[0]  = '0;
   assign br_root[0] = '0;
   assign br_side[0] = {a_dx, a_ok};
   assign bf_rad[0]  = rad_f;
   assign bf_rem[0]  = '0;
   assign bf_root[0] = '0;
   assign bf_side[0] = a_dz;
   assign bv_rad[0]  = a_rad_vy;
   assign bv_rem[0]  = '0;
   assign bv_root[0] = '0;
   assign bv_side[0] = a_vysat;

   for (genvar i = 0; i < NB; i++) begin : g_sqrt_b
      bals_sqrt_cell #(.RAD_W(RAD_W), .SIDE_W(34)) u_rise (
         .clock(clock), .en(en),
         .rad_i(br_rad[i]), .rem_i(br_rem[i]), .root_i(br_root[i]), .side_i(br_side[i]),
         .rad_o(br_rad[i+1]), .rem_o(br_rem[i+1]), .root_o(br_root[i+1]),
         .side_o(br_side[i+1])
      );
      bals_sqrt_cell #(.RAD_W(RAD_W), .SIDE_W(33)) u_fall (
         .clock(clock), .en(en),
         .rad_i(bf_rad[i]), .rem_i(bf_rem[i]), .root_i(bf_root[i]), .side_i(bf_side[i]),
         .rad_o(bf_rad[i+1]), .rem_o(bf_rem[i+1]), .root_o(bf_root[i+1]),
         .side_o(bf_side[i+1])
      );
      bals_sqrt_cell #(.RAD_W(RAD_W), .SIDE_W(1)) u_speed (
         .clock(clock), .en(en),
         .rad_i(bv_rad[i]), .rem_i(bv_rem[i]), .root_i(bv_root[i]), .side_i(bv_side[i]),
         .rad_o(bv_rad[i+1]), .rem_o(bv_rem[i+1]), .root_o(bv_root[i+1]),
         .side_o(bv_side[i+1])
      );
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vb_ff <= '0;
      end else if (en) begin
         vb_ff <= {vb_ff[NB-2:0], va_ff[NA-1]};
      end
   end

   logic [32:0]           tsum;
   logic [BALS_MAG_W-1:0] t_in, vy_in;

   always_comb begin
      tsum = {1'b0, br_root[NB]} + {1'b0, bf_root[NB]};
      if (tsum < 33'(MIN_TIME)) begin
         t_in = BALS_MAG_W'(MIN_TIME);
      end else if (tsum > 33'(MAX31)) begin
         t_in = MAX31;
      end else begin
         t_in = tsum[BALS_MAG_W-1:0];
      end
      vy_in = bv_side[NB][0] ? MAX31 : bv_root[NB][BALS_MAG_W-1:0];
   end

   logic                  t_vld_ff, t_ok_ff;
   logic [BALS_MAG_W-1:0] t_time_ff, t_vy_ff;
   logic signed [32:0]    t_dx_ff, t_dz_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         t_vld_ff <= 1'b0;
      end else if (en) begin
         t_vld_ff <= vb_ff[NB-1];
      end
      if (en) begin
         t_ok_ff   <= br_side[NB][0];
         t_dx_ff   <= br_side[NB][33:1];
         t_dz_ff   <= bf_side[NB];
         t_time_ff <= t_in;
         t_vy_ff   <= vy_in;
      end
   end

   // Horizontal velocity division chains.
   localparam int SCX_W = 2 + 2 * BALS_MAG_W;

   logic              negx, negz;
   logic [32:0]       magx33, magz33;
   logic [NUMC_W-1:0] cx_num [0:NC];
   logic [DENC_W-1:0] cx_den [0:NC];
   logic [DENC_W-1:0] cx_rem [0:NC];
   logic [NC-1:0]     cx_quo [0:NC];
   logic [SCX_W-1:0]  cx_side [0:NC];
   logic [NUMC_W-1:0] cz_num [0:NC];
   logic [DENC_W-1:0] cz_den [0:NC];
   logic [DENC_W-1:0] cz_rem [0:NC];
   logic [NC-1:0]     cz_quo [0:NC];
   logic [0:0]        cz_side [0:NC];
   logic [NC-1:0]     vc_ff;

   always_comb begin
      negx   = t_dx_ff[32];
      negz   = t_dz_ff[32];
      magx33 = negx ? 33'(-t_dx_ff) : t_dx_ff;
      magz33 = negz ? 33'(-t_dz_ff) : t_dz_ff;
   end

   assign cx_num[0]  = magx33[NUMC_W-1:0];
   assign cx_den[0]  = t_time_ff;
   assign cx_rem[0]  = '0;
   assign cx_quo[0]  = '0;
   assign cx_side[0] = {negx, t_ok_ff, t_time_ff, t_vy_ff};
   assign cz_num[0]  = magz33[NUMC_W-1:0];
   assign cz_den[0]  = t_time_ff;
   assign cz_rem[0]  = '0;
   assign cz_quo[0]  = '0;
   assign cz_side[0] = negz;

   for (genvar i = 0; i < NC; i++) begin : g_div_c
      bals_div_cell #(
         .NUM_W(NUMC_W), .DEN_W(DENC_W), .QUO_W(NC), .SIDE_W(SCX_W)
      ) u_velx (
         .clock(clock), .en(en),
         .num_i(cx_num[i]), .den_i(cx_den[i]), .rem_i(cx_rem[i]),
         .quo_i(cx_quo[i]), .side_i(cx_side[i]),
         .num_o(cx_num[i+1]), .den_o(cx_den[i+1]), .rem_o(cx_rem[i+1]),
         .quo_o(cx_quo[i+1]), .side_o(cx_side[i+1])
      );
      bals_div_cell #(
         .NUM_W(NUMC_W), .DEN_W(DENC_W), .QUO_W(NC), .SIDE_W(1)
      ) u_velz (
         .clock(clock), .en(en),
         .num_i(cz_num[i]), .den_i(cz_den[i]), .rem_i(cz_rem[i]),
         .quo_i(cz_quo[i]), .side_i(cz_side[i]),
         .num_o(cz_num[i+1]), .den_o(cz_den[i+1]), .rem_o(cz_rem[i+1]),
         .quo_o(cz_quo[i+1]), .side_o(cz_side[i+1])
      );
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vc_ff <= '0;
      end else if (en) begin
         vc_ff <= {vc_ff[NC-2:0], t_vld_ff};
      end
   end

   function automatic logic [31:0] sat_vel(input logic [NC-1:0] q, input logic neg);
      logic [NC-1:0] lim;
      logic [31:0]   mag;
      lim = neg ? NC'(33'h0_8000_0000) : NC'(33'h0_7FFF_FFFF);
      mag = (q > lim) ? lim[31:0] : q[31:0];
      return neg ? (32'd0 - mag) : mag;
   endfunction

   logic         c_ok;
   bals_rsp_type rsp_in;
   logic         rsp_valid_ff;
   bals_rsp_type rsp_ff;

   always_comb begin
      c_ok = cx_side[NC][SCX_W-2];
      rsp_in.solved      = c_ok;
      rsp_in.vel_x       = c_ok ? sat_vel(cx_quo[NC], cx_side[NC][SCX_W-1]) : '0;
      rsp_in.vel_z       = c_ok ? sat_vel(cz_quo[NC], cz_side[NC][0]) : '0;
      rsp_in.flight_time = c_ok ? cx_side[NC][2*BALS_MAG_W-1:BALS_MAG_W] : '0;
      rsp_in.vel_y       = c_ok ? cx_side[NC][BALS_MAG_W-1:0] : '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         rsp_valid_ff <= vc_ff[NC-1];
      end
      if (en) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   a_unsolved_zero : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.solved |->
         rsp_data.flight_time == '0 && rsp_data.vel_y == '0 &&
         rsp_data.vel_x == '0 && rsp_data.vel_z == '0)
      else $error("unsolved result carries non-zero fields");

   a_min_time : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.solved |-> rsp_data.flight_time >= BALS_MAG_W'(MIN_TIME))
      else $error("solved flight time below the minimum");

   a_hold_on_stall : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("result changed while it was stalled");

   a_reset_empty : assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid straight after reset");

endmodule
